/* rtl/core/bst_pkg.sv */
// bst_pkg: shared widths, status codes and defaults for the bounded span tracker
// no dependencies; imported by bounded_span_tracker and bst_ram
`default_nettype none

package bst_pkg;

  localparam int VAL_W             = 32;
  localparam int CAP_W             = 11;
  localparam int DEFAULT_MAX_ITEMS = 1024;
  localparam int DEFAULT_RAM_WIDTH = VAL_W;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_CAP_ZERO = 2'd2,
    ST_CLEARED  = 2'd3
  } add_status_t;

endpackage : bst_pkg

`default_nettype wire

/* rtl/core/bst_ram.sv */
// bst_ram: generic single write port, single read port ram with registered read
// depends on bst_pkg for its default width and depth
`default_nettype none

module bst_ram
  import bst_pkg::*;
#(
  parameter int WIDTH = DEFAULT_RAM_WIDTH,
  parameter int DEPTH = DEFAULT_MAX_ITEMS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : bst_ram

`default_nettype wire

/* rtl/core/bounded_span_tracker.sv */
// bounded_span_tracker: top level, sequencer around the value store
// depends on bst_pkg and bst_ram
`default_nettype none

// usage
// - one register, capacity, written with cfg_we/cfg_wdata while the block is idle;
//   values above MAX_ITEMS behave as MAX_ITEMS, zero rejects every add
// - a command beat is taken at a clock edge with start high and busy low;
//   command 0 adds new_value, command 1 clears the set
// - every beat gives exactly one result beat: done is high for one cycle with
//   add_status, span_ready, shortest_span, longest_span and stored_count
// - the receiver cannot stall; results are simply presented for one cycle
// - sequence: an add that is stored while values are held makes one ram read
//   per held value in S_SCAN, then updates the set in S_UPD and gives its
//   result in S_FIN; an add to an empty set skips S_SCAN; a clear, a full or a
//   zero capacity reject goes straight to S_FIN; busy stays high until the
//   result has gone out, so the next beat can be taken once back in S_IDLE
// - the scan streams the store through the single read port, one entry a
//   cycle, so the ram port sets the rate; a new beat is not taken until the
//   last one's result is out
// - reset empties the set, zeroes capacity and sets the shortest gap to all
//   ones; the store itself is not cleared, only entries below the count are used
module bounded_span_tracker
  import bst_pkg::*;
#(
  parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [CAP_W-1:0]  cfg_wdata,
  // command channel
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              command,
  input  wire logic signed [VAL_W-1:0] new_value,
  // result channel
  output      logic              done,
  output      logic [1:0]        add_status,
  output      logic              span_ready,
  output      logic [VAL_W-1:0]  shortest_span,
  output      logic [VAL_W-1:0]  longest_span,
  output      logic [CAP_W-1:0]  stored_count
);

  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  // architectural state
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] count;
  logic [VAL_W-1:0] least_value;
  logic [VAL_W-1:0] greatest_value;
  logic [VAL_W-1:0] least_gap;

  // per beat working registers
  logic [VAL_W-1:0] val_q;
  add_status_t      status_q;
  logic [CAP_W-1:0] rd_idx;
  logic             rd_valid;

  // ram ports
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;
  logic              ram_we;

  bst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(count)),
    .wdata (val_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // keys map signed order onto unsigned order
  logic [VAL_W-1:0] key_new;
  logic [VAL_W-1:0] key_old;
  logic [VAL_W:0]   diff_up;
  logic [VAL_W-1:0] diff_down;
  logic [VAL_W-1:0] gap;

  assign key_new   = val_q ^ SIGN_FLIP;
  assign key_old   = ram_rdata ^ SIGN_FLIP;
  assign diff_up   = {1'b0, key_new} - {1'b0, key_old};
  assign diff_down = key_old - key_new;
  // distance to the stored value, whichever side of the new value it lies
  assign gap       = diff_up[VAL_W] ? diff_down : diff_up[VAL_W-1:0];

  logic room;
  // room left under both the register and the store depth
  assign room = (32'(count) < 32'(capacity)) && (32'(count) < 32'(MAX_ITEMS));

  logic accept_beat;
  logic scan_last;
  assign accept_beat = start && (state == S_IDLE);
  assign scan_last   = rd_valid && (rd_idx == count);

  assign ram_raddr = (state == S_IDLE) ? '0 : ADDR_W'(rd_idx);
  assign ram_we    = (state == S_UPD);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (command || !room || (count == '0)) begin
            state_next = (!command && room) ? S_UPD : S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_UPD;
        end
      end
      S_UPD:   state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      capacity       <= '0;
      count          <= '0;
      least_value    <= '0;
      greatest_value <= '0;
      least_gap      <= '1;
      rd_idx         <= '0;
      rd_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (start && !command && room && (count != '0)) begin
            // entry 0 is being read this cycle
            rd_idx   <= CAP_W'(1);
            rd_valid <= 1'b1;
          end else begin
            rd_idx   <= '0;
            rd_valid <= 1'b0;
          end
          if (start && command) begin
            count          <= '0;
            least_value    <= '0;
            greatest_value <= '0;
            least_gap      <= '1;
          end
        end
        S_SCAN: begin
          if (rd_valid && (gap < least_gap)) begin
            least_gap <= gap;
          end
          if (rd_idx != count) begin
            rd_idx   <= rd_idx + CAP_W'(1);
            rd_valid <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
          end
        end
        S_UPD: begin
          if (count == '0) begin
            least_value    <= val_q;
            greatest_value <= val_q;
          end else begin
            if (key_new < (least_value ^ SIGN_FLIP)) begin
              least_value <= val_q;
            end
            if (key_new > (greatest_value ^ SIGN_FLIP)) begin
              greatest_value <= val_q;
            end
          end
          count <= count + CAP_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // beat payload and status, no reset needed
  always_ff @(posedge clk) begin
    if (accept_beat) begin
      val_q <= new_value;
      if (command) begin
        status_q <= ST_CLEARED;
      end else if (room) begin
        status_q <= ST_ACCEPTED;
      end else if (capacity == '0) begin
        status_q <= ST_CAP_ZERO;
      end else begin
        status_q <= ST_FULL;
      end
    end
  end

  // result beat comes straight from the settled state
  assign busy          = (state != S_IDLE);
  assign done          = (state == S_FIN);
  assign span_ready    = (count >= CAP_W'(2));
  assign add_status    = status_q;
  assign shortest_span = span_ready ? least_gap : '0;
  assign longest_span  = span_ready ? (greatest_value - least_value) : '0;
  assign stored_count  = count;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_ITEMS))
    else $error("held count beyond store depth");

  a_beat_takes_time: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("idle straight after an accepted beat");

  a_update_bumps_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> (count == $past(count) + CAP_W'(1)))
    else $error("update cycle did not add one value");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_idx <= count && rd_idx != '0))
    else $error("scan index outside held entries");

  a_store_on_accept: assert property (@(posedge clk) disable iff (rst)
    (done && status_q != ST_ACCEPTED && status_q != ST_CLEARED) |-> $stable(count))
    else $error("count moved on a rejected beat");

endmodule : bounded_span_tracker

`default_nettype wire

/* tb/sv/bounded_span_tracker_tb.sv */
// bounded_span_tracker_tb: self-checking testbench for the bounded span tracker
// drives command beats from a queue, predicts every result beat and checks it field by field
// depends on bst_pkg and the bounded_span_tracker rtl
module bounded_span_tracker_tb;
  import bst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS = DEFAULT_MAX_ITEMS;

  // command encodings on the command port
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7fff_ffff;

  // slowest correct run is about 600 beats, each scanning at most the whole store,
  // plus sender gaps; the limit allows several times that
  localparam int CYCLE_LIMIT = 8_000_000;

  typedef struct {
    logic                    cmd;
    logic signed [VAL_W-1:0] value;
  } span_cmd_t;

  typedef struct packed {
    add_status_t      status;
    logic             ready;
    logic [VAL_W-1:0] shortest;
    logic [VAL_W-1:0] longest;
    logic [CAP_W-1:0] count;
  } span_result_t;

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata = '0;
  logic                    start     = 1'b0;
  logic                    command   = CMD_ADD;
  logic signed [VAL_W-1:0] new_value = '0;
  logic                    busy;
  logic                    done;
  logic [1:0]              add_status;
  logic                    span_ready;
  logic [VAL_W-1:0]        shortest_span;
  logic [VAL_W-1:0]        longest_span;
  logic [CAP_W-1:0]        stored_count;

  bounded_span_tracker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .new_value    (new_value),
    .done         (done),
    .add_status   (add_status),
    .span_ready   (span_ready),
    .shortest_span(shortest_span),
    .longest_span (longest_span),
    .stored_count (stored_count)
  );

  // beats waiting to be driven, and predicted results waiting for the block
  span_cmd_t    pending_cmds[$];
  span_result_t expected_spans[$];

  // shadow copy of the tracker state
  logic signed [VAL_W-1:0] set_values[MAX_ITEMS];
  int unsigned             set_count;
  logic signed [VAL_W-1:0] set_least;
  logic signed [VAL_W-1:0] set_greatest;
  logic [VAL_W-1:0]        set_gap;
  logic [CAP_W-1:0]        set_capacity;

  int          sender_idle_pct = 0;
  int          mismatches      = 0;
  int          beats_sent      = 0;
  int          results_checked = 0;
  int          full_seen       = 0;
  int          cap_zero_seen   = 0;
  int          clears_seen     = 0;
  int          peak_count      = 0;
  int unsigned cycle_count     = 0;
  logic signed [VAL_W-1:0] last_drawn = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // shadow state back to its reset values
  function automatic void reset_span_state();
    set_count    = 0;
    set_least    = '0;
    set_greatest = '0;
    set_gap      = '1;
    set_capacity = '0;
  endfunction

  // apply one command beat to the shadow state and work out its result beat
  function automatic span_result_t predict_span(logic cmd, logic signed [VAL_W-1:0] v);
    span_result_t            r;
    int unsigned             limit;
    logic                    have_below;
    logic                    have_above;
    logic signed [VAL_W-1:0] below;
    logic signed [VAL_W-1:0] above;
    logic signed [VAL_W-1:0] s;
    logic [VAL_W-1:0]        gap;
    limit      = (set_capacity > MAX_ITEMS) ? MAX_ITEMS : set_capacity;
    have_below = 1'b0;
    have_above = 1'b0;
    below      = '0;
    above      = '0;
    if (cmd == CMD_CLEAR) begin
      set_count    = 0;
      set_least    = '0;
      set_greatest = '0;
      set_gap      = '1;
      r.status     = ST_CLEARED;
    end else if (set_count < limit) begin
      // nearest held values at or below and at or above the new one
      for (int i = 0; i < set_count; i++) begin
        s = set_values[i];
        if (s <= v && (!have_below || s > below)) begin
          below      = s;
          have_below = 1'b1;
        end
        if (s >= v && (!have_above || s < above)) begin
          above      = s;
          have_above = 1'b1;
        end
      end
      // gaps are exact unsigned differences, wrapping as 32-bit words
      if (have_below) begin
        gap = v - below;
        if (gap < set_gap) set_gap = gap;
      end
      if (have_above) begin
        gap = above - v;
        if (gap < set_gap) set_gap = gap;
      end
      if (set_count == 0) begin
        set_least    = v;
        set_greatest = v;
      end else begin
        if (v < set_least) set_least = v;
        if (v > set_greatest) set_greatest = v;
      end
      set_values[set_count] = v;
      set_count++;
      r.status = ST_ACCEPTED;
    end else if (set_capacity == 0) begin
      r.status = ST_CAP_ZERO;
    end else begin
      r.status = ST_FULL;
    end
    r.ready    = (set_count >= 2);
    r.shortest = r.ready ? set_gap : '0;
    r.longest  = r.ready ? VAL_W'(set_greatest - set_least) : '0;
    r.count    = set_count[CAP_W-1:0];
    return r;
  endfunction

  // driver: holds start until the beat is taken, then predicts its result
  always @(posedge clk) begin : drive_cmds
    span_cmd_t    nxt;
    span_result_t pred;
    if (rst) begin
      start <= 1'b0;
      reset_span_state();
    end else begin
      // the register write lands at this edge; the block is idle by construction
      if (cfg_we) set_capacity = cfg_wdata;
      if (start && !busy) begin
        pred           = predict_span(command, new_value);
        expected_spans = {expected_spans, pred};
        beats_sent++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = pending_cmds.pop_front();
          start     <= 1'b1;
          command   <= nxt.cmd;
          new_value <= nxt.value;
        end else begin
          // idle cycle: payload wanders so it is never trusted without start
          start     <= 1'b0;
          command   <= 1'($urandom_range(0, 1));
          new_value <= $urandom;
        end
      end
    end
  end

  // monitor: every done pulse is a result beat, compared with the oldest prediction
  always @(posedge clk) begin : check_results
    span_result_t want;
    span_result_t got;
    if (!rst && done) begin
      got.status   = add_status_t'(add_status);
      got.ready    = span_ready;
      got.shortest = shortest_span;
      got.longest  = longest_span;
      got.count    = stored_count;
      if (expected_spans.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d count %0d",
                 $time, got.status, got.count);
        mismatches++;
      end else begin
        want = expected_spans.pop_front();
        results_checked++;
        if (got.status !== want.status) begin
          $display("%0t: add_status expected %0d actual %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.ready !== want.ready) begin
          $display("%0t: span_ready expected %0b actual %0b", $time, want.ready, got.ready);
          mismatches++;
        end
        if (got.shortest !== want.shortest) begin
          $display("%0t: shortest_span expected %0h actual %0h",
                   $time, want.shortest, got.shortest);
          mismatches++;
        end
        if (got.longest !== want.longest) begin
          $display("%0t: longest_span expected %0h actual %0h",
                   $time, want.longest, got.longest);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $display("%0t: stored_count expected %0d actual %0d", $time, want.count, got.count);
          mismatches++;
        end
        case (want.status)
          ST_FULL:     full_seen++;
          ST_CAP_ZERO: cap_zero_seen++;
          ST_CLEARED:  clears_seen++;
          default:     ;
        endcase
        if (want.count > peak_count) peak_count = int'(want.count);
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL bounded_span_tracker");
      $finish;
    end
  end

  function automatic void queue_cmd(logic cmd, logic signed [VAL_W-1:0] v);
    span_cmd_t c;
    c.cmd        = cmd;
    c.value      = v;
    pending_cmds = {pending_cmds, c};
  endfunction

  // value mix: wide random, close neighbours, repeats, edges of the range, near zero
  function automatic logic signed [VAL_W-1:0] draw_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      4, 5:    v = last_drawn + (int'($urandom_range(0, 16)) - 8);
      6:       v = last_drawn;
      7:       v = $urandom_range(0, 1) ? INT_MAX - $urandom_range(0, 3)
                                        : INT_MIN + $urandom_range(0, 3);
      8:       v = int'($urandom_range(0, 255)) - 128;
      default: v = $urandom;
    endcase
    last_drawn = v;
    return v;
  endfunction

  // mostly small capacities so the set fills and rejects often
  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      6:       return '0;
      7:       return CAP_W'(1);
      8:       return CAP_W'($urandom_range(25, 64));
      9:       return CAP_W'($urandom_range(MAX_ITEMS + 1, 2047));
      default: return CAP_W'($urandom_range(2, 24));
    endcase
  endfunction

  // block is idle once nothing is queued, start is low and every result is in;
  // a few spare cycles cover the tail of the last beat
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || expected_spans.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // a stretch of random settings, each followed by a burst of beats
  task automatic run_random(int n_items);
    int issued;
    int burst;
    issued = 0;
    while (issued < n_items) begin
      burst = $urandom_range(8, 40);
      write_capacity(pick_capacity());
      // sometimes keep the old set so a lowered capacity meets a fuller set
      if ($urandom_range(0, 99) < 40) queue_cmd(CMD_CLEAR, $urandom);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 99) < 7) queue_cmd(CMD_CLEAR, $urandom);
        else queue_cmd(CMD_ADD, draw_value());
      end
      issued += burst;
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    sender_idle_pct = 27;

    // capacity still zero from reset: adds rejected, clear still answers
    queue_cmd(CMD_ADD, 32'sd5);
    queue_cmd(CMD_CLEAR, $urandom);
    queue_cmd(CMD_ADD, INT_MAX);

    // room for one value: no span yet, then full
    write_capacity(CAP_W'(1));
    queue_cmd(CMD_ADD, INT_MIN);
    queue_cmd(CMD_ADD, 32'sd7);

    // extremes of the value range, then a duplicate for a zero gap
    write_capacity(CAP_W'(8));
    queue_cmd(CMD_CLEAR, $urandom);
    queue_cmd(CMD_ADD, INT_MIN);
    queue_cmd(CMD_ADD, INT_MAX);
    queue_cmd(CMD_ADD, 32'sd0);
    queue_cmd(CMD_ADD, 32'sd0);
    queue_cmd(CMD_ADD, -32'sd1);
    queue_cmd(CMD_ADD, 32'sd1);

    // capacity lowered under the held count: held values stay, adds are full until the clear
    write_capacity(CAP_W'(3));
    queue_cmd(CMD_ADD, 32'sd9);
    queue_cmd(CMD_CLEAR, $urandom);
    queue_cmd(CMD_ADD, 32'sd4);
    queue_cmd(CMD_ADD, 32'sd4);

    write_capacity(CAP_W'(2));
    queue_cmd(CMD_CLEAR, $urandom);
    queue_cmd(CMD_ADD, 32'sd10);
    queue_cmd(CMD_ADD, 32'sd30);
    queue_cmd(CMD_ADD, 32'sd20);

    run_random(170);

    sender_idle_pct = 50;
    run_random(170);

    sender_idle_pct = 0;
    run_random(170);

    // capacity beyond the store behaves as the store depth
    write_capacity(CAP_W'(2047));
    queue_cmd(CMD_CLEAR, $urandom);
    for (int k = 0; k < 6; k++) queue_cmd(CMD_ADD, draw_value());
    // zero capacity with values held still reports zero capacity
    write_capacity('0);
    queue_cmd(CMD_ADD, draw_value());
    queue_cmd(CMD_CLEAR, $urandom);

    wait_idle();
    repeat (16) @(negedge clk);
    if (expected_spans.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_spans.size());
      mismatches++;
    end

    $display("run covered %0d command beats and %0d result beats, largest set %0d values",
             beats_sent, results_checked, peak_count);
    $display("rejects seen: %0d full, %0d zero capacity; %0d clears; %0d mismatches",
             full_seen, cap_zero_seen, clears_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS bounded_span_tracker");
    end else begin
      $display("FAIL bounded_span_tracker");
    end
    $finish;
  end

endmodule
